// File: rtl/bast_pkg.sv
// Shared types and constants for the bounded adjacency slot table.
// Used by bast_ctrl, bast_dpath and bounded_adjacency_slot_table; no dependencies.
package bast_pkg;

  localparam int NODES_DEF        = 128;
  localparam int PARENT_SLOTS_DEF = 8;
  localparam int CHILD_SLOTS_DEF  = 8;

  localparam int NODE_W     = 7;
  localparam int WEIGHT_W   = 16;
  localparam int SLOT_IDX_W = 3;
  localparam int CFG_W      = 8;
  localparam int COUNT_W    = 4;
  localparam int ID_OUT_W   = 8;
  localparam int TOTAL_W    = 11;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_W-1:0]    NODE_COUNT_RST = 8'd128;
  localparam logic [ID_OUT_W-1:0] EMPTY_CODE     = 8'd128;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX      = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_TEST   = 2'd1,
    ACT_COUNT  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

  // input word, last field (node_a) in the lowest bits
  typedef struct packed {
    logic [6:0]            pad;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [WEIGHT_W-1:0]   edge_weight;
    logic [NODE_W-1:0]     node_b;
    logic [NODE_W-1:0]     node_a;
  } in_word_t;

  // result word, last field (edge_found) in the lowest bits
  typedef struct packed {
    logic                  pad;
    logic [TOTAL_W-1:0]    edge_total;
    logic [WEIGHT_W-1:0]   slot_weight;
    logic [ID_OUT_W-1:0]   slot_child;
    logic [ID_OUT_W-1:0]   slot_parent;
    logic [COUNT_W-1:0]    child_count;
    logic [COUNT_W-1:0]    parent_count;
    logic                  child_list_full;
    logic                  parent_list_full;
    logic                  bad_index;
    logic                  edge_found;
  } out_word_t;

endpackage

// File: rtl/bast_ctrl.sv
// Controller for the bounded adjacency slot table: clear pass, accept, commit.
// Depends on bast_pkg; drives commands to bast_dpath.
module bast_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bast_pkg::status_t  status,
  output bast_pkg::cmd_t     cmd
);

  bast_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bast_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bast_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = bast_pkg::ST_IDLE;
        end
      end
      bast_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = bast_pkg::ST_LOOK;
        end
      end
      bast_pkg::ST_LOOK: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = bast_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bast_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/bast_dpath.sv
// Datapath for the bounded adjacency slot table: slot memories, fill counts,
// edge total and output register. Depends on bast_pkg; commanded by bast_ctrl.
module bast_dpath #(
  parameter int NODES        = bast_pkg::NODES_DEF,
  parameter int PARENT_SLOTS = bast_pkg::PARENT_SLOTS_DEF,
  parameter int CHILD_SLOTS  = bast_pkg::CHILD_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bast_pkg::cmd_t                     cmd,
  output bast_pkg::status_t                  status,
  input  logic [bast_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [bast_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic [bast_pkg::CFG_W-1:0]         node_count,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bast_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int NAW = $clog2(NODES);
  localparam int PSW = (PARENT_SLOTS > 1) ? $clog2(PARENT_SLOTS) : 1;
  localparam int PCW = $clog2(PARENT_SLOTS + 1);
  localparam int CCW = $clog2(CHILD_SLOTS + 1);
  localparam int PAW = (NODES * PARENT_SLOTS > 1) ? $clog2(NODES * PARENT_SLOTS) : 1;
  localparam int CAW = (NODES * CHILD_SLOTS > 1) ? $clog2(NODES * CHILD_SLOTS) : 1;

  localparam int NW = bast_pkg::NODE_W;

  // memories
  logic [PARENT_SLOTS-1:0][NW-1:0]   prow_mem  [NODES];
  logic [bast_pkg::WEIGHT_W-1:0]     wgt_mem   [NODES*PARENT_SLOTS];
  logic [NW-1:0]                     child_mem [NODES*CHILD_SLOTS];
  logic [PCW-1:0]                    pfill_mem [NODES];
  logic [CCW-1:0]                    cfill_mem [NODES];

  bast_pkg::in_word_t  in_w;
  bast_pkg::action_t   in_act;
  logic [NAW-1:0]      in_a_node, in_b_node, in_p_node;
  logic [PAW-1:0]      rd_paddr;
  logic [CAW-1:0]      rd_caddr;

  // captured item
  bast_pkg::action_t                act_r;
  logic [NW-1:0]                    a_r, b_r;
  logic [bast_pkg::WEIGHT_W-1:0]    w_r;
  logic [bast_pkg::SLOT_IDX_W-1:0]  s_r;

  // registered read data
  logic [PCW-1:0]                   pfill_q;
  logic [CCW-1:0]                   cfill_q;
  logic [PARENT_SLOTS-1:0][NW-1:0]  prow_q;
  logic [bast_pkg::WEIGHT_W-1:0]    wgt_q;
  logic [NW-1:0]                    child_q;

  logic [NAW-1:0]                   clr_r;
  logic [bast_pkg::TOTAL_W-1:0]     edge_r, edge_after;
  logic                             out_valid_r, out_valid_nxt;
  bast_pkg::out_word_t              out_data_r, res;

  logic                             a_ok, b_ok, ins_ok, p_room, c_room, found;
  logic [NAW-1:0]                   a_node_r, b_node_r;
  logic [PARENT_SLOTS-1:0][NW-1:0]  prow_new;
  logic [PAW-1:0]                   wr_paddr;
  logic [CAW-1:0]                   wr_caddr;

  assign in_w      = bast_pkg::in_word_t'(in_tdata);
  assign in_act    = bast_pkg::action_t'(in_tuser);
  assign in_a_node = NAW'(in_w.node_a);
  assign in_b_node = NAW'(in_w.node_b);
  assign in_p_node = (in_act == bast_pkg::ACT_INSERT || in_act == bast_pkg::ACT_TEST) ?
                     in_b_node : in_a_node;
  assign rd_paddr  = PAW'(32'(in_a_node) * PARENT_SLOTS + 32'(in_w.slot_index));
  assign rd_caddr  = CAW'(32'(in_a_node) * CHILD_SLOTS + 32'(in_w.slot_index));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_act;
      a_r     <= in_w.node_a;
      b_r     <= in_w.node_b;
      w_r     <= in_w.edge_weight;
      s_r     <= in_w.slot_index;
      pfill_q <= pfill_mem[in_p_node];
      cfill_q <= cfill_mem[in_a_node];
      prow_q  <= prow_mem[in_p_node];
      wgt_q   <= wgt_mem[rd_paddr];
      child_q <= child_mem[rd_caddr];
    end
  end

  // commit decode
  assign a_node_r = NAW'(a_r);
  assign b_node_r = NAW'(b_r);
  assign a_ok     = (8'(a_r) < node_count) && (32'(a_r) < NODES);
  assign b_ok     = (8'(b_r) < node_count) && (32'(b_r) < NODES);
  assign ins_ok   = (act_r == bast_pkg::ACT_INSERT) && a_ok && b_ok;
  assign p_room   = pfill_q < PCW'(PARENT_SLOTS);
  assign c_room   = cfill_q < CCW'(CHILD_SLOTS);
  assign wr_paddr = PAW'(32'(b_node_r) * PARENT_SLOTS + 32'(pfill_q));
  assign wr_caddr = CAW'(32'(a_node_r) * CHILD_SLOTS + 32'(cfill_q));

  always_comb begin
    prow_new = prow_q;
    prow_new[pfill_q[PSW-1:0]] = a_r;
  end

  always_comb begin
    found = 1'b0;
    for (int k = 0; k < PARENT_SLOTS; k++) begin
      if (PCW'(k) < pfill_q && prow_q[k] == a_r) begin
        found = 1'b1;
      end
    end
  end

  assign edge_after = (ins_ok && p_room && edge_r != bast_pkg::TOTAL_MAX) ?
                      edge_r + 1'b1 : edge_r;

  always_comb begin
    res             = '0;
    res.slot_parent = bast_pkg::EMPTY_CODE;
    res.slot_child  = bast_pkg::EMPTY_CODE;
    res.edge_total  = edge_after;
    unique case (act_r)
      bast_pkg::ACT_INSERT: begin
        if (!(a_ok && b_ok)) begin
          res.bad_index = 1'b1;
        end else begin
          res.parent_list_full = !p_room;
          res.child_list_full  = !c_room;
        end
      end
      bast_pkg::ACT_TEST: begin
        if (!(a_ok && b_ok)) begin
          res.bad_index = 1'b1;
        end else begin
          res.edge_found = found;
        end
      end
      bast_pkg::ACT_COUNT: begin
        if (!a_ok) begin
          res.bad_index = 1'b1;
        end else begin
          res.parent_count = bast_pkg::COUNT_W'(pfill_q);
          res.child_count  = bast_pkg::COUNT_W'(cfill_q);
        end
      end
      bast_pkg::ACT_READ: begin
        if (!a_ok) begin
          res.bad_index = 1'b1;
        end else begin
          if (32'(s_r) < 32'(pfill_q)) begin
            res.slot_parent = bast_pkg::ID_OUT_W'(prow_q[PSW'(s_r)]);
            res.slot_weight = wgt_q;
          end
          if (32'(s_r) < 32'(cfill_q)) begin
            res.slot_child = bast_pkg::ID_OUT_W'(child_q);
          end
        end
      end
    endcase
  end

  // memory writes: clear pass after reset, then write-back on commit
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      pfill_mem[clr_r] <= '0;
      cfill_mem[clr_r] <= '0;
    end else if (cmd.commit && ins_ok) begin
      if (p_room) begin
        prow_mem[b_node_r]  <= prow_new;
        wgt_mem[wr_paddr]   <= w_r;
        pfill_mem[b_node_r] <= pfill_q + 1'b1;
      end
      if (c_room) begin
        child_mem[wr_caddr] <= b_r;
        cfill_mem[a_node_r] <= cfill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      edge_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.commit) begin
        edge_r <= edge_after;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid_nxt     = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign status.out_free   = !out_valid_r || out_tready;
  assign status.clear_last = (32'(clr_r) == NODES - 1);
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;

`ifndef SYNTHESIS
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an untaken word");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!cmd.capture && !cmd.commit))
    else $error("item activity during clear pass");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (32'(pfill_q) <= PARENT_SLOTS && 32'(cfill_q) <= CHILD_SLOTS))
    else $error("fill count beyond slot count");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n)) |-> (edge_r >= $past(edge_r)))
    else $error("edge total decreased");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(edge_r))
    else $error("edge total moved without a commit");
`endif

endmodule

// File: rtl/bounded_adjacency_slot_table.sv
// Top level of the bounded adjacency slot table: config register, controller, datapath.
// Depends on bast_pkg, bast_ctrl and bast_dpath.
//
// Graph edge store with PARENT_SLOTS parent slots (id and weight) and CHILD_SLOTS
// child slots per node. After reset the block runs a clearing pass over the
// per-node fill counts (NODES entries, 128 by default) with in_tready low; cfg
// writes are taken at any time. Each word is captured in ST_IDLE, reading the
// node's parent row, fill counts and slot entries from the memories; ST_LOOK then
// decides and writes back into the same memories once the output register is
// free. No new word is taken before that commit. Every word yields one result word.
module bounded_adjacency_slot_table #(
  parameter int NODES        = bast_pkg::NODES_DEF,
  parameter int PARENT_SLOTS = bast_pkg::PARENT_SLOTS_DEF,
  parameter int CHILD_SLOTS  = bast_pkg::CHILD_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_a[6:0], node_b[13:7], edge_weight[29:14], slot_index[32:30], zero[39:33]
  input  logic [bast_pkg::IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [bast_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // edge_found[0], bad_index[1], parent_list_full[2], child_list_full[3],
  // parent_count[7:4], child_count[11:8], slot_parent[19:12], slot_child[27:20],
  // slot_weight[43:28], edge_total[54:44], zero[55]
  output logic [bast_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bast_pkg::CFG_W-1:0]       cfg_data
);

  logic [bast_pkg::CFG_W-1:0] node_count_r;
  bast_pkg::cmd_t             cmd;
  bast_pkg::status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bast_pkg::NODE_COUNT_RST;
    end else if (cfg_valid) begin
      node_count_r <= cfg_data;
    end
  end

  bast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bast_dpath #(
    .NODES        (NODES),
    .PARENT_SLOTS (PARENT_SLOTS),
    .CHILD_SLOTS  (CHILD_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .node_count (node_count_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
